// ===== design/llps_pkg.sv =====
`timescale 1ns / 1ps

package llps_pkg;

	localparam int PACKET_BYTES = 23;
	localparam int RAMP_ENTRIES = 127;
	localparam int NUM_CH       = 3;

	localparam int BYTE_W    = $clog2(PACKET_BYTES);
	localparam int ADDR_W    = 2 + BYTE_W;
	localparam int MEM_DEPTH = NUM_CH << BYTE_W;
	localparam int STEP_W    = 7;

	localparam logic [BYTE_W-1:0] LEVEL_HI_BYTE = BYTE_W'(8);
	localparam logic [BYTE_W-1:0] LEVEL_LO_BYTE = BYTE_W'(9);
	localparam logic [BYTE_W-1:0] SEND_END      = BYTE_W'(PACKET_BYTES - 1);
	localparam logic [BYTE_W-1:0] READ_END      = BYTE_W'(PACKET_BYTES - 2);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_SEND  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] channel;
		logic [4:0] byte_index;
		logic [7:0] byte_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] out_channel;
		logic       is_last;
	} result_t;

	typedef struct packed {
		logic        adv;
		logic [1:0]  ch;
		logic [15:0] ceiling;
	} ramp_ctl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RAMP,
		ST_WLO,
		ST_EMIT
	} state_t;

	localparam logic [9:0] LVL [64] = '{
		10'h3FF, 10'h3EE, 10'h3DE, 10'h3CE, 10'h3BE, 10'h3AD, 10'h39D, 10'h38D,
		10'h37D, 10'h36C, 10'h35C, 10'h34C, 10'h33C, 10'h32B, 10'h31B, 10'h30B,
		10'h2FB, 10'h2EA, 10'h2DA, 10'h2CA, 10'h2BA, 10'h2AA, 10'h299, 10'h289,
		10'h279, 10'h269, 10'h258, 10'h248, 10'h238, 10'h228, 10'h217, 10'h207,
		10'h1F7, 10'h1E7, 10'h1D6, 10'h1C6, 10'h1B6, 10'h1A6, 10'h195, 10'h185,
		10'h175, 10'h165, 10'h155, 10'h144, 10'h134, 10'h124, 10'h114, 10'h103,
		10'h0F3, 10'h0E3, 10'h0D3, 10'h0C2, 10'h0B2, 10'h0A2, 10'h092, 10'h081,
		10'h071, 10'h061, 10'h051, 10'h040, 10'h030, 10'h020, 10'h010, 10'h000
	};

	function automatic logic [9:0] ramp_level(input logic [STEP_W-1:0] i);
		logic [9:0] r;
		if (int'(i) >= 127 || int'(i) >= RAMP_ENTRIES) begin
			r = 10'd0;
		end else begin
			r = LVL[i[6:1]];
		end
		return r;
	endfunction

	function automatic logic [7:0] init_byte(input logic [1:0] ch,
			input logic [BYTE_W-1:0] idx);
		logic [7:0] r;
		if (idx == '0) begin
			r = {2'b00, ch, 4'b0000};
		end else if (int'(idx) == 2 + 2 * int'(ch) || int'(idx) == 3 + 2 * int'(ch)) begin
			r = 8'h11;
		end else begin
			r = 8'h00;
		end
		return r;
	endfunction

endpackage

// ===== design/led_level_packet_sequencer.sv =====
`timescale 1ns / 1ps
// After reset the packet memory is loaded with its start pattern, one byte a cycle, all 69
// bytes; busy stays high until that is done. Ramp and channel state reset at once.
// A write does not raise busy. A send first writes the level's high byte, then its low byte,
// then emits its bytes, one byte every cycle, 23 in all. A read emits 22 bytes at the same
// rate. Each byte is read through the registered memory read port.
// Results are strobed for one cycle each; the receiver cannot stall them.
module led_level_packet_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  llps_pkg::cmd_t    cmd,
	output logic              result_valid,
	output llps_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	llps_pkg::state_t st_q, st_d;

	logic [llps_pkg::BYTE_W-1:0] cnt_q, cnt_d;
	logic [llps_pkg::BYTE_W-1:0] end_q, end_d;
	logic [1:0]                  ch_q, ch_d;
	logic [1:0]                  next_ch_q, next_ch_d;
	logic [7:0]                  lo_q, lo_d;
	logic                        vld_s1, vld_d;
	logic                        last_s1, last_d;
	logic [1:0]                  ch_s1;

	logic [15:0] red_max_q, green_max_q, blue_max_q;

	logic                        mem_we;
	logic [llps_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic [llps_pkg::ADDR_W-1:0] mem_raddr;
	logic [7:0]                  mem_rdata;

	llps_pkg::ramp_ctl_t ramp_ctl;
	logic [15:0]         ramp_level;

	logic       accept;
	logic [5:0] idx_w;

	assign cfg_ready = 1'b1;
	assign busy      = (st_q != llps_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign idx_w     = {1'b0, cmd.byte_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_max_q   <= 16'hFFFF;
			green_max_q <= 16'hFFFF;
			blue_max_q  <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				llps_pkg::CH_RED:   red_max_q   <= cfg_data;
				llps_pkg::CH_GREEN: green_max_q <= cfg_data;
				llps_pkg::CH_BLUE:  blue_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ramp_ctl.adv = (st_q == llps_pkg::ST_RAMP);
		ramp_ctl.ch  = ch_q;
		unique case (ch_q)
			llps_pkg::CH_RED:   ramp_ctl.ceiling = red_max_q;
			llps_pkg::CH_GREEN: ramp_ctl.ceiling = green_max_q;
			default:            ramp_ctl.ceiling = blue_max_q;
		endcase
	end

	llps_ramp u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ramp_ctl),
		.level  (ramp_level)
	);

	llps_ram #(
		.WIDTH (8),
		.DEPTH (llps_pkg::MEM_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		end_d     = end_q;
		ch_d      = ch_q;
		next_ch_d = next_ch_q;
		lo_d      = lo_q;
		vld_d     = 1'b0;
		last_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {ch_q, cnt_q};
		mem_wdata = 8'h00;
		mem_raddr = {ch_q, cnt_q};
		unique case (st_q)
			llps_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = llps_pkg::init_byte(ch_q, cnt_q);
				if (cnt_q == llps_pkg::SEND_END) begin
					cnt_d = '0;
					if (ch_q == llps_pkg::CH_BLUE) begin
						ch_d = llps_pkg::CH_RED;
						st_d = llps_pkg::ST_IDLE;
					end else begin
						ch_d = ch_q + 2'd1;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			llps_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (cmd.req_type == llps_pkg::REQ_WRITE) begin
						if (cmd.channel != 2'd3 && int'(idx_w) < llps_pkg::PACKET_BYTES - 1) begin
							mem_we    = 1'b1;
							mem_waddr = {cmd.channel, idx_w[llps_pkg::BYTE_W-1:0]};
							mem_wdata = cmd.byte_value;
						end
					end else if (cmd.req_type == llps_pkg::REQ_SEND) begin
						ch_d      = next_ch_q;
						next_ch_d = (next_ch_q == llps_pkg::CH_BLUE) ? llps_pkg::CH_RED
							: next_ch_q + 2'd1;
						end_d     = llps_pkg::SEND_END;
						cnt_d     = '0;
						st_d      = llps_pkg::ST_RAMP;
					end else if (cmd.req_type == llps_pkg::REQ_READ) begin
						if (cmd.channel != 2'd3) begin
							ch_d  = cmd.channel;
							end_d = llps_pkg::READ_END;
							cnt_d = '0;
							st_d  = llps_pkg::ST_EMIT;
						end
					end else begin
					end
				end
			end
			llps_pkg::ST_RAMP: begin
				mem_we    = 1'b1;
				mem_waddr = {ch_q, llps_pkg::LEVEL_HI_BYTE};
				mem_wdata = ramp_level[15:8];
				lo_d      = ramp_level[7:0];
				st_d      = llps_pkg::ST_WLO;
			end
			llps_pkg::ST_WLO: begin
				mem_we    = 1'b1;
				mem_waddr = {ch_q, llps_pkg::LEVEL_LO_BYTE};
				mem_wdata = lo_q;
				st_d      = llps_pkg::ST_EMIT;
			end
			llps_pkg::ST_EMIT: begin
				vld_d  = 1'b1;
				last_d = (cnt_q == end_q);
				if (cnt_q == end_q) begin
					cnt_d = '0;
					st_d  = llps_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				st_d = llps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= llps_pkg::ST_INIT;
			cnt_q     <= '0;
			end_q     <= '0;
			ch_q      <= llps_pkg::CH_RED;
			next_ch_q <= llps_pkg::CH_RED;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			st_q      <= st_d;
			cnt_q     <= cnt_d;
			end_q     <= end_d;
			ch_q      <= ch_d;
			next_ch_q <= next_ch_d;
			vld_s1    <= vld_d;
			last_s1   <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		ch_s1 <= ch_q;
	end

	assign result_valid       = vld_s1;
	assign result.out_byte    = mem_rdata;
	assign result.out_channel = ch_s1;
	assign result.is_last     = last_s1;

endmodule

// ===== design/llps_ram.sv =====
`timescale 1ns / 1ps

module llps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/llps_ramp.sv =====
`timescale 1ns / 1ps

module llps_ramp (
	input  logic                clk,
	input  logic                arst_n,
	input  llps_pkg::ramp_ctl_t ctl,
	output logic [15:0]         level
);

	logic [llps_pkg::STEP_W-1:0] step_q [llps_pkg::NUM_CH];
	logic                        fall_q [llps_pkg::NUM_CH];

	logic [llps_pkg::STEP_W-1:0] s;
	logic [llps_pkg::STEP_W-1:0] s_n;
	logic [llps_pkg::STEP_W-1:0] idx;
	logic [llps_pkg::STEP_W:0]   s_inc;
	logic                        f;
	logic                        f_n;
	logic [15:0]                 raw;

	always_comb begin
		s     = step_q[ctl.ch];
		f     = fall_q[ctl.ch];
		s_inc = {1'b0, s} + 1'b1;
		if (f) begin
			s_n = (s != '0) ? s - 1'b1 : s;
			idx = s_n;
			f_n = (s_n != '0);
		end else begin
			idx = s;
			if (s_inc >= (llps_pkg::STEP_W + 1)'(llps_pkg::RAMP_ENTRIES)) begin
				s_n = llps_pkg::STEP_W'(llps_pkg::RAMP_ENTRIES);
				f_n = 1'b1;
			end else begin
				s_n = s_inc[llps_pkg::STEP_W-1:0];
				f_n = 1'b0;
			end
		end
		raw   = {llps_pkg::ramp_level(idx), 6'b000000};
		level = (raw > ctl.ceiling) ? ctl.ceiling : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < llps_pkg::NUM_CH; c++) begin
				step_q[c] <= llps_pkg::STEP_W'(llps_pkg::RAMP_ENTRIES);
				fall_q[c] <= 1'b1;
			end
		end else if (ctl.adv) begin
			step_q[ctl.ch] <= s_n;
			fall_q[ctl.ch] <= f_n;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import llps_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam logic [1:0] CH_NONE     = 2'd3;
	localparam logic [1:0] REG_RED     = 2'd0;
	localparam logic [1:0] REG_GREEN   = 2'd1;
	localparam logic [1:0] REG_BLUE    = 2'd2;
	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int         RAMP_STEPS  = 127;
	localparam int         SETTLE      = 30;
	localparam int         PHASE_ITEMS = 94;

	localparam logic [9:0] DRIVE_LEVELS [64] = '{
		10'h3FF, 10'h3EE, 10'h3DE, 10'h3CE, 10'h3BE, 10'h3AD, 10'h39D, 10'h38D,
		10'h37D, 10'h36C, 10'h35C, 10'h34C, 10'h33C, 10'h32B, 10'h31B, 10'h30B,
		10'h2FB, 10'h2EA, 10'h2DA, 10'h2CA, 10'h2BA, 10'h2AA, 10'h299, 10'h289,
		10'h279, 10'h269, 10'h258, 10'h248, 10'h238, 10'h228, 10'h217, 10'h207,
		10'h1F7, 10'h1E7, 10'h1D6, 10'h1C6, 10'h1B6, 10'h1A6, 10'h195, 10'h185,
		10'h175, 10'h165, 10'h155, 10'h144, 10'h134, 10'h124, 10'h114, 10'h103,
		10'h0F3, 10'h0E3, 10'h0D3, 10'h0C2, 10'h0B2, 10'h0A2, 10'h092, 10'h081,
		10'h071, 10'h061, 10'h051, 10'h040, 10'h030, 10'h020, 10'h010, 10'h000
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        result_valid;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [7:0]  packet_bytes [3][PACKET_BYTES];
	int          ramp_pos [3];
	logic        ramp_down [3];
	logic [15:0] ramp_ceiling [3];
	logic [1:0]  send_channel;
	result_t     expected_bytes [$];
	int          mismatches;
	bit          idle_on;

	led_level_packet_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [9:0] level_at(input int step);
		logic [9:0] v;
		if (step >= RAMP_STEPS) begin
			v = 10'd0;
		end else begin
			v = DRIVE_LEVELS[step / 2];
		end
		return v;
	endfunction

	function automatic void reset_packets();
		for (int c = 0; c < 3; c++) begin
			for (int b = 0; b < PACKET_BYTES; b++) begin
				packet_bytes[c][b] = 8'h00;
			end
			packet_bytes[c][0]         = 8'(c << 4);
			packet_bytes[c][2 + 2 * c] = 8'h11;
			packet_bytes[c][3 + 2 * c] = 8'h11;
			ramp_pos[c]                = RAMP_STEPS;
			ramp_down[c]               = 1'b1;
			ramp_ceiling[c]            = 16'hFFFF;
		end
		send_channel = CH_RED;
	endfunction

	function automatic void advance_level(input logic [1:0] ch);
		int          s;
		logic [15:0] v;
		s = ramp_pos[ch];
		if (ramp_down[ch]) begin
			if (s != 0) begin
				s = s - 1;
			end
			v = {level_at(s), 6'b0};
			if (s == 0) begin
				ramp_down[ch] = 1'b0;
			end
		end else begin
			v = {level_at(s), 6'b0};
			s = s + 1;
			if (s >= RAMP_STEPS) begin
				s = RAMP_STEPS;
				ramp_down[ch] = 1'b1;
			end
		end
		ramp_pos[ch] = s;
		if (v > ramp_ceiling[ch]) begin
			v = ramp_ceiling[ch];
		end
		packet_bytes[ch][8] = v[15:8];
		packet_bytes[ch][9] = v[7:0];
	endfunction

	function automatic void queue_packet(input logic [1:0] ch, input int count);
		result_t r;
		for (int i = 0; i < count; i++) begin
			r.out_byte    = packet_bytes[ch][i];
			r.out_channel = ch;
			r.is_last     = (i == count - 1);
			expected_bytes.push_back(r);
		end
	endfunction

	function automatic void apply_command(input cmd_t c);
		logic [1:0] ch;
		case (c.req_type)
			REQ_WRITE: begin
				if (c.channel != CH_NONE && int'(c.byte_index) < PACKET_BYTES - 1) begin
					packet_bytes[c.channel][c.byte_index] = c.byte_value;
				end
			end
			REQ_SEND: begin
				ch = send_channel;
				advance_level(ch);
				send_channel = (ch == CH_BLUE) ? CH_RED : ch + 2'd1;
				queue_packet(ch, PACKET_BYTES);
			end
			REQ_READ: begin
				if (c.channel != CH_NONE) begin
					queue_packet(c.channel, PACKET_BYTES - 1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50) begin
			n = 0;
		end else if (r < 90) begin
			n = $urandom_range(1, 4);
		end else begin
			n = $urandom_range(10, 60);
		end
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_command(input cmd_t c);
		idle_gap();
		@(negedge clk);
		cmd   = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		apply_command(c);
	endtask

	task automatic send_fields(input logic [1:0] req, input logic [1:0] ch,
			input logic [4:0] idx, input logic [7:0] val);
		cmd_t c;
		c.req_type   = req;
		c.channel    = ch;
		c.byte_index = idx;
		c.byte_value = val;
		send_command(c);
	endtask

	// The sender holds off until every byte has arrived and the block has gone quiet.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_ceiling(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx != REG_SPARE) begin
			ramp_ceiling[idx] = val;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
			end else begin
				want = expected_bytes.pop_front();
				if (result.out_byte !== want.out_byte) begin
					mismatches++;
					$display("%0t: out_byte expected %02h actual %02h",
						$time, want.out_byte, result.out_byte);
				end
				if (result.out_channel !== want.out_channel) begin
					mismatches++;
					$display("%0t: out_channel expected %0d actual %0d",
						$time, want.out_channel, result.out_channel);
				end
				if (result.is_last !== want.is_last) begin
					mismatches++;
					$display("%0t: is_last expected %0b actual %0b",
						$time, want.is_last, result.is_last);
				end
			end
		end
	end

	task automatic test_reset_pattern();
		send_fields(REQ_READ, CH_RED, 5'd0, 8'h00);
		send_fields(REQ_READ, CH_GREEN, 5'd0, 8'h00);
		send_fields(REQ_READ, CH_BLUE, 5'd0, 8'h00);
	endtask

	task automatic test_byte_writes();
		send_fields(REQ_WRITE, CH_RED, 5'd0, 8'hFF);
		send_fields(REQ_WRITE, CH_GREEN, 5'd21, 8'hA5);
		send_fields(REQ_WRITE, CH_BLUE, 5'd22, 8'h5A);
		send_fields(REQ_WRITE, CH_RED, 5'd31, 8'hFF);
		send_fields(REQ_WRITE, CH_NONE, 5'd5, 8'h77);
		send_fields(REQ_WRITE, CH_BLUE, 5'd9, 8'h00);
		send_fields(REQ_READ, CH_RED, 5'd31, 8'hFF);
		send_fields(REQ_READ, CH_GREEN, 5'd0, 8'h00);
		send_fields(REQ_READ, CH_BLUE, 5'd0, 8'h00);
	endtask

	task automatic test_ignored_commands();
		send_fields(REQ_READ, CH_NONE, 5'd0, 8'h00);
		send_fields(REQ_UNUSED, CH_NONE, 5'd31, 8'hFF);
	endtask

	task automatic test_send_rotation();
		repeat (4) send_fields(REQ_SEND, CH_NONE, 5'd0, 8'h00);
		send_fields(REQ_READ, CH_RED, 5'd0, 8'h00);
	endtask

	task automatic set_phase_ceilings(input int phase);
		case (phase)
			1: begin
				write_ceiling(REG_RED, 16'h0000);
				write_ceiling(REG_GREEN, 16'h0000);
				write_ceiling(REG_BLUE, 16'h0000);
			end
			2: begin
				write_ceiling(REG_RED, 16'($urandom_range(0, 65535)));
				write_ceiling(REG_GREEN, 16'($urandom_range(0, 65535)));
				write_ceiling(REG_BLUE, 16'($urandom_range(0, 65535)));
				write_ceiling(REG_SPARE, 16'($urandom_range(0, 65535)));
			end
			3: begin
				write_ceiling(REG_RED, 16'hFFFF);
				write_ceiling(REG_GREEN, 16'h8000);
				write_ceiling(REG_BLUE, 16'h0040);
			end
			4: begin
				write_ceiling(REG_RED, 16'($urandom_range(0, 16'h1000)));
				write_ceiling(REG_GREEN, 16'($urandom_range(0, 16'h1000)));
				write_ceiling(REG_BLUE, 16'($urandom_range(0, 16'h1000)));
			end
			default: begin
			end
		endcase
	endtask

	// Mostly sends, so that every channel's ramp runs to the bottom and turns.
	task automatic test_random_traffic();
		cmd_t c;
		int   r;
		for (int p = 0; p < 5; p++) begin
			drain_results();
			set_phase_ceilings(p);
			idle_on = (p != 2);
			repeat (PHASE_ITEMS) begin
				r            = $urandom_range(0, 99);
				c.channel    = ($urandom_range(0, 15) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
				c.byte_index = 5'($urandom_range(0, 31));
				c.byte_value = 8'($urandom_range(0, 255));
				if (r < 85) begin
					c.req_type = REQ_SEND;
				end else if (r < 93) begin
					c.req_type = REQ_WRITE;
				end else if (r < 98) begin
					c.req_type = REQ_READ;
				end else begin
					c.req_type = REQ_UNUSED;
				end
				send_command(c);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_RED;
		cfg_data   = 16'h0000;
		mismatches = 0;
		idle_on    = 1'b1;
		reset_packets();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_pattern();
		test_byte_writes();
		test_ignored_commands();
		test_send_rotation();
		test_random_traffic();

		drain_results();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
